@@ sv/prrt_pkg.sv @@
// Shared types and codes for the IPv4/port range rule table.
// Used by every module of the block and by its port checker.
`default_nettype none

package prrt_pkg;

  localparam int unsigned RULE_SLOTS_DEF = 32;
  localparam int unsigned MAX_RESULTS    = 32;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_DEL   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_LIST  = 2'd3;

  localparam logic [3:0] ST_ADDED     = 4'd0;
  localparam logic [3:0] ST_INVALID   = 4'd1;
  localparam logic [3:0] ST_DELETED   = 4'd2;
  localparam logic [3:0] ST_NOT_FOUND = 4'd3;
  localparam logic [3:0] ST_ACCEPTED  = 4'd4;
  localparam logic [3:0] ST_REJECTED  = 4'd5;
  localparam logic [3:0] ST_ILLEGAL   = 4'd6;
  localparam logic [3:0] ST_LISTED    = 4'd7;
  localparam logic [3:0] ST_EMPTY     = 4'd8;
  localparam logic [3:0] ST_FULL      = 4'd9;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ip_low;
    logic [31:0] ip_high;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] rule_ip_low;
    logic [31:0] rule_ip_high;
    logic [15:0] rule_port_low;
    logic [15:0] rule_port_high;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip_low;
    logic [31:0] ip_high;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } rule_t;

  typedef struct packed {
    logic bounds_ok;
    logic equal;
    logic hit;
    logic single;
  } cmp_flags_t;

endpackage

`default_nettype wire

@@ sv/prrt_rule_mem.sv @@
// Rule storage: one write port and one read port with registered read data.
// Depends on prrt_pkg for the rule type.
`default_nettype none

module prrt_rule_mem #(
  parameter int unsigned DEPTH = prrt_pkg::RULE_SLOTS_DEF,
  parameter int unsigned AW    = 5
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire prrt_pkg::rule_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output prrt_pkg::rule_t      rdata_o
);
  import prrt_pkg::*;

  rule_t mem_q [DEPTH];
  rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/prrt_cmp.sv @@
// Shared compare unit: checks a rule's bounds, its equality with the
// request bounds, and whether it contains the requested address and port.
// Depends on prrt_pkg for the rule, item and flag types.
`default_nettype none

module prrt_cmp (
  input  wire prrt_pkg::rule_t    r_i,
  input  wire prrt_pkg::in_item_t q_i,
  output prrt_pkg::cmp_flags_t    flags_o
);
  import prrt_pkg::*;

  always_comb begin
    flags_o.bounds_ok = (r_i.ip_low <= r_i.ip_high) && (r_i.port_low <= r_i.port_high);
    flags_o.equal     = (r_i.ip_low == q_i.ip_low) && (r_i.ip_high == q_i.ip_high) &&
                        (r_i.port_low == q_i.port_low) && (r_i.port_high == q_i.port_high);
    flags_o.hit       = (r_i.ip_low <= q_i.ip_low) && (q_i.ip_low <= r_i.ip_high) &&
                        (r_i.port_low <= q_i.port_low) && (q_i.port_low <= r_i.port_high);
    flags_o.single    = (q_i.ip_low == q_i.ip_high) && (q_i.port_low == q_i.port_high);
  end

endmodule

`default_nettype wire

@@ sv/ip_port_range_rule_table.sv @@
// Top level of the IPv4/port range rule table: sequencer, rule storage and
// compare unit. Depends on prrt_pkg, prrt_rule_mem and prrt_cmp.
`default_nettype none

// First-match rule table for IPv4 address ranges with port ranges, kept in
// insertion order. The block takes one transaction at a time: after an input
// transaction is accepted, in_stall_o stays high until its last result has
// been loaded into the output register. Add, and any request rejected on its
// bounds, loads its single result in the decode state and returns to idle,
// ready for the next transaction. Check, delete and list walk the stored
// rules through one memory read port and one shared compare unit, one rule
// per cycle. A delete that matches before the last rule restarts the read
// at the slot after the match and moves each later rule down one slot, one
// rule per cycle. Every cycle in which a result waits under out_stall_i
// holds the sequencer. A list emits one result per cycle while the output
// side keeps stall low. The rule memory needs no clearing after reset: only
// slots below the rule count are ever read.
module ip_port_range_rule_table #(
  parameter int unsigned RULE_SLOTS = prrt_pkg::RULE_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire prrt_pkg::in_item_t in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output prrt_pkg::out_item_t    out_o
);
  import prrt_pkg::*;

  localparam int unsigned IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(RULE_SLOTS + 1);
  localparam bit          LIST_CAP = RULE_SLOTS > MAX_RESULTS;
  localparam logic [CNT_W-1:0] LIST_LAST = LIST_CAP ? CNT_W'(MAX_RESULTS - 1) : '0;
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RULE_SLOTS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ridx_q, ridx_d;
  logic [CNT_W-1:0] eidx_q, eidx_d;
  logic             dv_q, dv_d;
  in_item_t         cur_q;
  out_item_t        out_q, res;
  logic             out_valid_q, out_valid_d;
  logic             emit;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  rule_t            wdata, rdata, cur_rule, cmp_rule;
  cmp_flags_t       fl;

  logic             adv, is_last, list_last;
  logic [CNT_W-1:0] cnt_m1, eidx_m1, ridx_p1;

  assign cur_rule = '{ip_low: cur_q.ip_low, ip_high: cur_q.ip_high,
                      port_low: cur_q.port_low, port_high: cur_q.port_high};
  // The compare unit checks the request's own bounds while decoding and the
  // stored rule under scan otherwise.
  assign cmp_rule = (state_q == S_DECODE) ? cur_rule : rdata;

  prrt_cmp u_cmp (
    .r_i     (cmp_rule),
    .q_i     (cur_q),
    .flags_o (fl)
  );

  prrt_rule_mem #(
    .DEPTH (RULE_SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign adv       = !out_valid_q || !out_stall_i;
  assign cnt_m1    = cnt_q - CNT_W'(1);
  assign eidx_m1   = eidx_q - CNT_W'(1);
  assign ridx_p1   = ridx_q + CNT_W'(1);
  assign is_last   = eidx_q == cnt_m1;
  assign list_last = is_last || (LIST_CAP && (eidx_q == LIST_LAST));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ridx_d  = ridx_q;
    eidx_d  = eidx_q;
    dv_d    = dv_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = cur_rule;
    re      = 1'b0;
    raddr   = '0;
    emit    = 1'b0;
    res     = '0;
    res.last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (adv) begin
          ridx_d = '0;
          dv_d   = 1'b0;
          state_d = S_IDLE;
          unique case (cur_q.command)
            CMD_ADD: begin
              emit = 1'b1;
              if (!fl.bounds_ok) begin
                res.status = ST_INVALID;
              end else if (cnt_q == FULL_CNT) begin
                res.status = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = cnt_q[IDX_W-1:0];
                cnt_d      = cnt_q + CNT_W'(1);
                res.status = ST_ADDED;
              end
            end
            CMD_DEL: begin
              if (!fl.bounds_ok) begin
                emit       = 1'b1;
                res.status = ST_INVALID;
              end else if (cnt_q == '0) begin
                emit       = 1'b1;
                res.status = ST_NOT_FOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_CHECK: begin
              if (!fl.single) begin
                emit       = 1'b1;
                res.status = ST_ILLEGAL;
              end else if (cnt_q == '0) begin
                emit       = 1'b1;
                res.status = ST_REJECTED;
              end else begin
                state_d = S_SCAN;
              end
            end
            CMD_LIST: begin
              if (cnt_q == '0) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (adv) begin
          // Read the next rule while the previous one is being compared.
          if (ridx_q < cnt_q) begin
            re     = 1'b1;
            raddr  = ridx_q[IDX_W-1:0];
            eidx_d = ridx_q;
            ridx_d = ridx_p1;
            dv_d   = 1'b1;
          end else begin
            dv_d = 1'b0;
          end
          if (dv_q) begin
            unique case (cur_q.command)
              CMD_CHECK: begin
                if (fl.hit) begin
                  emit       = 1'b1;
                  res.status = ST_ACCEPTED;
                  state_d    = S_IDLE;
                end else if (is_last) begin
                  emit       = 1'b1;
                  res.status = ST_REJECTED;
                  state_d    = S_IDLE;
                end
              end
              CMD_DEL: begin
                if (fl.equal) begin
                  if (is_last) begin
                    cnt_d      = cnt_m1;
                    emit       = 1'b1;
                    res.status = ST_DELETED;
                    state_d    = S_IDLE;
                  end else begin
                    ridx_d  = eidx_q + CNT_W'(1);
                    dv_d    = 1'b0;
                    state_d = S_SHIFT;
                  end
                end else if (is_last) begin
                  emit       = 1'b1;
                  res.status = ST_NOT_FOUND;
                  state_d    = S_IDLE;
                end
              end
              CMD_LIST: begin
                emit               = 1'b1;
                res.status         = ST_LISTED;
                res.rule_ip_low    = rdata.ip_low;
                res.rule_ip_high   = rdata.ip_high;
                res.rule_port_low  = rdata.port_low;
                res.rule_port_high = rdata.port_high;
                res.last           = list_last;
                if (list_last) begin
                  state_d = S_IDLE;
                end
              end
              CMD_ADD: begin
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end

      S_SHIFT: begin
        if (adv) begin
          if (ridx_q < cnt_q) begin
            re     = 1'b1;
            raddr  = ridx_q[IDX_W-1:0];
            eidx_d = ridx_q;
            ridx_d = ridx_p1;
            dv_d   = 1'b1;
          end else begin
            dv_d = 1'b0;
          end
          // Each rule read at slot k is written back to slot k - 1.
          if (dv_q) begin
            we    = 1'b1;
            waddr = eidx_m1[IDX_W-1:0];
            wdata = rdata;
            if (is_last) begin
              cnt_d      = cnt_m1;
              emit       = 1'b1;
              res.status = ST_DELETED;
              state_d    = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ridx_q      <= '0;
      eidx_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ridx_q      <= ridx_d;
      eidx_q      <= eidx_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      cur_q <= in_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ sv/prrt_checker.sv @@
// Port-level checks for the IPv4/port range rule table, bound to its top.
// Depends on prrt_pkg for the item types and status codes.
`default_nettype none

module prrt_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire prrt_pkg::in_item_t  in_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire prrt_pkg::out_item_t out_o
);
  import prrt_pkg::*;

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction was still in progress");

  // A stalled input transaction is held unchanged by the sender.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_i))
    else $error("stalled input transaction changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.status <= ST_FULL)
    else $error("result status out of range");

  // Only a listed rule carries rule fields; every other result stands alone.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != ST_LISTED) |->
      out_o.last && (out_o.rule_ip_low == '0) && (out_o.rule_ip_high == '0) &&
      (out_o.rule_port_low == '0) && (out_o.rule_port_high == '0))
    else $error("single result with rule fields or without last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

endmodule

bind ip_port_range_rule_table prrt_checker u_prrt_checker (.*);

`default_nettype wire

@@ tb/tb_ip_port_range_rule_table.sv @@
// Testbench for ip_port_range_rule_table: a rule table tracker predicts each
// result while tasks drive directed and random commands under random stalls.
// Depends on prrt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_ip_port_range_rule_table;
  import prrt_pkg::*;

  localparam int unsigned RULE_SLOTS      = RULE_SLOTS_DEF;
  localparam int          NUM_RANDOM      = 270;
  localparam int          HOLD_OFF_CYCLES = 400;

  // Keeps its own copy of the rule list and the results still owed by the block.
  class rule_table_tracker;
    rule_t       rules[$];
    out_item_t   due_results[$];
    int unsigned slots;
    int          errors;

    function new(int unsigned n);
      slots  = n;
      errors = 0;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void owe_single(logic [3:0] st);
      out_item_t res;
      res        = '0;
      res.status = st;
      res.last   = 1'b1;
      due_results.push_back(res);
    endfunction

    function void note_request(in_item_t req);
      int        hit;
      int        n;
      bit        bad_bounds;
      out_item_t res;
      hit        = -1;
      bad_bounds = (req.ip_low > req.ip_high) || (req.port_low > req.port_high);
      case (req.command)
        CMD_ADD: begin
          if (bad_bounds) begin
            owe_single(ST_INVALID);
          end else if (rules.size() >= slots) begin
            owe_single(ST_FULL);
          end else begin
            rules.push_back(rule_t'{req.ip_low, req.ip_high, req.port_low, req.port_high});
            owe_single(ST_ADDED);
          end
        end
        CMD_DEL: begin
          if (bad_bounds) begin
            owe_single(ST_INVALID);
          end else begin
            for (int i = 0; i < rules.size() && hit < 0; i++) begin
              if (rules[i] == rule_t'{req.ip_low, req.ip_high, req.port_low, req.port_high})
                hit = i;
            end
            if (hit >= 0) begin
              rules.delete(hit);
              owe_single(ST_DELETED);
            end else begin
              owe_single(ST_NOT_FOUND);
            end
          end
        end
        CMD_CHECK: begin
          if (req.ip_low != req.ip_high || req.port_low != req.port_high) begin
            owe_single(ST_ILLEGAL);
          end else begin
            for (int i = 0; i < rules.size() && hit < 0; i++) begin
              if (rules[i].ip_low <= req.ip_low && req.ip_low <= rules[i].ip_high &&
                  rules[i].port_low <= req.port_low && req.port_low <= rules[i].port_high)
                hit = i;
            end
            owe_single((hit >= 0) ? ST_ACCEPTED : ST_REJECTED);
          end
        end
        default: begin
          if (rules.size() == 0) begin
            owe_single(ST_EMPTY);
          end else begin
            n = (rules.size() < MAX_RESULTS) ? rules.size() : MAX_RESULTS;
            for (int i = 0; i < n; i++) begin
              res.status         = ST_LISTED;
              res.rule_ip_low    = rules[i].ip_low;
              res.rule_ip_high   = rules[i].ip_high;
              res.rule_port_low  = rules[i].port_low;
              res.rule_port_high = rules[i].port_high;
              res.last           = (i == n - 1);
              due_results.push_back(res);
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (due_results.size() == 0) begin
        $error("unexpected result transaction: status %0d", got.status);
        errors++;
        return;
      end
      exp_res = due_results.pop_front();
      compare_field("status", 32'(exp_res.status), 32'(got.status));
      compare_field("rule_ip_low", exp_res.rule_ip_low, got.rule_ip_low);
      compare_field("rule_ip_high", exp_res.rule_ip_high, got.rule_ip_high);
      compare_field("rule_port_low", 32'(exp_res.rule_port_low), 32'(got.rule_port_low));
      compare_field("rule_port_high", 32'(exp_res.rule_port_high), 32'(got.rule_port_high));
      compare_field("last", 32'(exp_res.last), 32'(got.last));
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_o;

  bit quiet;
  bit hold_off_req;

  rule_table_tracker tracker = new(RULE_SLOTS);

  always #5 clk_i = ~clk_i;

  ip_port_range_rule_table #(
    .RULE_SLOTS (RULE_SLOTS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // Output side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      tracker.check_result(out_o);
  end

  // Offers one transaction and holds it until accepted, then maybe idles.
  task automatic drive_item(input in_item_t req);
    in_i       <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_request(req);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send(input logic [1:0] cmd, input logic [31:0] il, input logic [31:0] ih,
                      input logic [15:0] pl, input logic [15:0] ph);
    drive_item(in_item_t'{cmd, il, ih, pl, ph});
  endtask

  function automatic void pick_ip_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 4))
      0: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      1: begin
        lo = $urandom_range(0, 40);
        hi = lo + $urandom_range(0, 60);
      end
      2: begin
        hi = 32'hFFFF_FFFF - $urandom_range(0, 40);
        lo = hi - $urandom_range(0, 60);
      end
      default: begin
        lo = ($urandom_range(0, 1) ? 32'h0A00_0000 : 32'hC0A8_0100) + $urandom_range(0, 200);
        hi = lo + $urandom_range(0, 80);
      end
    endcase
  endfunction

  function automatic void pick_port_range(output logic [15:0] lo, output logic [15:0] hi);
    logic [15:0] a;
    logic [15:0] b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      1: begin
        lo = 16'($urandom_range(0, 20));
        hi = lo + 16'($urandom_range(0, 30));
      end
      2: begin
        hi = 16'hFFFF - 16'($urandom_range(0, 20));
        lo = hi - 16'($urandom_range(0, 30));
      end
      default: begin
        lo = ($urandom_range(0, 1) ? 16'd80 : 16'd8000) + 16'($urandom_range(0, 40));
        hi = lo + 16'($urandom_range(0, 40));
      end
    endcase
  endfunction

  // Bounds with the lower one strictly above the upper one; the command is kept.
  function automatic void reversed_bounds(inout in_item_t req);
    logic [31:0] il;
    logic [15:0] pl;
    il = $urandom;
    if (il == 0) il = 1;
    pl = 16'($urandom_range(1, 65535));
    req.ip_low    = il;
    req.ip_high   = $urandom % il;
    req.port_low  = pl;
    req.port_high = 16'($urandom_range(0, 32'(pl) - 1));
    // Sometimes only one of the two pairs is reversed.
    case ($urandom_range(0, 2))
      0: pick_ip_range(req.ip_low, req.ip_high);
      1: pick_port_range(req.port_low, req.port_high);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] point_in(logic [31:0] lo, logic [31:0] hi);
    longint unsigned span;
    span = longint'(hi) - longint'(lo) + 1;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      default: return lo + 32'(({$urandom, $urandom}) % span);
    endcase
  endfunction

  function automatic in_item_t make_request(int phase);
    in_item_t req;
    rule_t    r;
    int       roll;
    roll = $urandom_range(0, 99);
    req.ip_low    = $urandom;
    req.ip_high   = $urandom;
    req.port_low  = 16'($urandom);
    req.port_high = 16'($urandom);
    case (phase)
      0: req.command = (roll < 60) ? CMD_ADD : (roll < 70) ? CMD_DEL :
                       (roll < 90) ? CMD_CHECK : CMD_LIST;
      1: req.command = (roll < 30) ? CMD_ADD : (roll < 55) ? CMD_DEL :
                       (roll < 88) ? CMD_CHECK : CMD_LIST;
      default: req.command = (roll < 10) ? CMD_ADD : (roll < 60) ? CMD_DEL :
                             (roll < 88) ? CMD_CHECK : CMD_LIST;
    endcase
    roll = $urandom_range(0, 99);
    if (tracker.rules.size() != 0)
      r = tracker.rules[$urandom_range(0, tracker.rules.size() - 1)];
    else
      r = rule_t'{32'h0A00_0000, 32'h0A00_00FF, 16'd80, 16'd90};
    case (req.command)
      CMD_ADD: begin
        if (roll < 15) begin
          reversed_bounds(req);
        end else if (roll < 25 && tracker.rules.size() != 0) begin
          {req.ip_low, req.ip_high, req.port_low, req.port_high} = r;
        end else begin
          pick_ip_range(req.ip_low, req.ip_high);
          pick_port_range(req.port_low, req.port_high);
        end
      end
      CMD_DEL: begin
        if (roll < 10) begin
          reversed_bounds(req);
        end else if (roll < 80 && tracker.rules.size() != 0) begin
          {req.ip_low, req.ip_high, req.port_low, req.port_high} = r;
          // A near miss on one bound must not match.
          if (roll < 25) begin
            case ($urandom_range(0, 3))
              0: req.ip_low--;
              1: req.ip_high++;
              2: req.port_low--;
              default: req.port_high++;
            endcase
          end
        end else begin
          pick_ip_range(req.ip_low, req.ip_high);
          pick_port_range(req.port_low, req.port_high);
        end
      end
      CMD_CHECK: begin
        if (roll < 10) begin
          req.ip_high = req.ip_low ^ (32'd1 << $urandom_range(0, 31));
        end else if (roll < 20) begin
          req.ip_high   = req.ip_low;
          req.port_high = req.port_low ^ (16'd1 << $urandom_range(0, 15));
        end else begin
          if (roll >= 30) begin
            req.ip_low   = point_in(r.ip_low, r.ip_high);
            req.port_low = 16'(point_in(32'(r.port_low), 32'(r.port_high)));
          end
          req.ip_high   = req.ip_low;
          req.port_high = req.port_low;
        end
      end
      default: ;
    endcase
    return req;
  endfunction

  initial begin
    int       full_step;
    int       phase;
    in_item_t req;
    full_step  = 0;
    quiet      = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_i       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extreme bounds, reversed bounds, illegal checks,
    // deletes at the head and in the middle, and duplicates.
    send(CMD_LIST,  32'h0, 32'h0, 16'h0, 16'h0);
    send(CMD_CHECK, 32'h0, 32'h0, 16'h0, 16'h0);
    send(CMD_ADD,   32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
    send(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_ADD,   32'h5, 32'h4, 16'h10, 16'h20);
    send(CMD_ADD,   32'h4, 32'h5, 16'h21, 16'h20);
    send(CMD_CHECK, 32'h1, 32'h2, 16'h50, 16'h50);
    send(CMD_CHECK, 32'h1, 32'h1, 16'h50, 16'h51);
    send(CMD_ADD,   32'h0A00_0000, 32'h0A00_00FF, 16'd80, 16'd80);
    send(CMD_ADD,   32'hC0A8_0000, 32'hC0A8_FFFF, 16'd1000, 16'd2000);
    send(CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send(CMD_LIST,  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0);
    send(CMD_DEL,   32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
    send(CMD_CHECK, 32'h0, 32'h0, 16'h0, 16'h0);
    send(CMD_CHECK, 32'h0A00_0010, 32'h0A00_0010, 16'd80, 16'd80);
    send(CMD_CHECK, 32'h0A00_0010, 32'h0A00_0010, 16'd81, 16'd81);
    send(CMD_DEL,   32'hC0A8_FFFF, 32'hC0A8_0000, 16'd1000, 16'd2000);
    send(CMD_DEL,   32'hC0A8_0000, 32'hC0A8_FFFF, 16'd1000, 16'd2001);
    send(CMD_DEL,   32'hC0A8_0000, 32'hC0A8_FFFF, 16'd1000, 16'd2000);
    send(CMD_ADD,   32'h0A00_0000, 32'h0A00_00FF, 16'd80, 16'd80);
    send(CMD_LIST,  32'h0, 32'h0, 16'h0, 16'h0);
    send(CMD_DEL,   32'h0A00_0000, 32'h0A00_00FF, 16'd80, 16'd80);
    send(CMD_LIST,  32'h0, 32'h0, 16'h0, 16'h0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      phase = (i < 90) ? 0 : (i < 180) ? 1 : 2;
      quiet = (i >= NUM_RANDOM - 40);
      if (i == 70)
        hold_off_req = 1'b1;
      req = make_request(phase);
      // Once the table is full: a valid add, a reversed add and a full list.
      if (tracker.rules.size() == RULE_SLOTS && full_step < 3) begin
        case (full_step)
          0: req.command = CMD_ADD;
          1: begin
            req.command = CMD_ADD;
            reversed_bounds(req);
          end
          default: req.command = CMD_LIST;
        endcase
        if (full_step == 0)
          pick_ip_range(req.ip_low, req.ip_high);
        if (full_step == 0)
          pick_port_range(req.port_low, req.port_high);
        full_step++;
      end
      drive_item(req);
    end
    in_valid_i <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
